### rtl/pest_pkg.sv
// Shared types and constants for the periodic event slot timer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pest_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 16;
   localparam int MASK_W  = 16;

   localparam logic [COUNT_W-1:0] MIN_PERIOD_RESET = COUNT_W'(10);
   localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_POLL   = 2'd1,
      OP_ADD    = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // latch the accepted transaction, clear sweep state
      logic rd_issue;      // read both stores at the sweep index, advance it
      logic single_write;  // apply add or delete to one slot
      logic emit;          // load the result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic idx_last;      // sweep index is on the last slot
      logic out_free;      // output register can take a result this cycle
   } status_type;

endpackage

`default_nettype wire

### rtl/pest_ctrl.sv
// Sequencer of the periodic event slot timer: accepts a transaction and
// steps the datapath through a single write or a sweep. Needs pest_pkg.
`default_nettype none

module pest_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [pest_pkg::OP_W-1:0]  req_operation,
   input  wire pest_pkg::status_type       sts,
   output pest_pkg::cmd_type               cmd
);
   import pest_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   op_type    op;

   assign op        = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (op inside {OP_TICK, OP_POLL}) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_SINGLE;
               end
            end
         end
         ST_SINGLE: begin
            cmd.single_write = 1'b1;
            state_in         = ST_DONE;
         end
         ST_SWEEP: begin
            cmd.rd_issue = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot's update lands at the end of this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pest_datapath.sv
// Datapath of the periodic event slot timer: min_period register, slot
// stores, sweep pipeline and output register. Needs pest_pkg.
`default_nettype none

module pest_datapath #(
   parameter int SLOTS = pest_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pest_pkg::OP_W-1:0]     req_operation,
   input  wire logic [pest_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [pest_pkg::COUNT_W-1:0]  req_period,
   input  wire logic                          req_has_handler,
   input  wire logic                          csr_write_enable,
   input  wire logic [pest_pkg::COUNT_W-1:0]  csr_write_data,
   input  wire pest_pkg::cmd_type             cmd,
   output pest_pkg::status_type               sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [pest_pkg::MASK_W-1:0]        rsp_fired_mask
);
   import pest_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int SW = 7;                  // holds any slot number and SLOTS itself
   localparam int EW = SLOTS + MASK_W;

   // configuration
   logic [COUNT_W-1:0] min_period_ff;

   // latched transaction
   op_type             op_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [COUNT_W-1:0] period_ff;
   logic               handler_ff;

   // slot state
   logic [COUNT_W-1:0] elapsed_mem [SLOTS];
   logic [COUNT_W-1:0] period_mem  [SLOTS];
   logic [SLOTS-1:0]   elapsed_ok_ff;
   logic [SLOTS-1:0]   period_ok_ff;
   logic [SLOTS-1:0]   enabled_ff;
   logic [SLOTS-1:0]   action_ff;

   // sweep pipeline
   logic [IW-1:0]      idx_ff;
   logic               rd_valid_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic [COUNT_W-1:0] rd_elapsed_ff;
   logic [COUNT_W-1:0] rd_period_ff;
   logic               rd_el_ok_ff;
   logic               rd_pe_ok_ff;
   logic [SLOTS-1:0]   mask_ff;

   // output register
   logic               rsp_valid_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;

   logic [SW-1:0]      slot_wide;
   logic               slot_in_range;
   logic [IW-1:0]      slot_idx;
   logic [COUNT_W-1:0] clamped;
   logic [COUNT_W-1:0] el_cur;
   logic [COUNT_W-1:0] pe_cur;
   logic               due;
   logic [COUNT_W-1:0] el_next;
   logic [EW-1:0]      mask_ext;

   assign slot_wide     = SW'(slot_ff);
   assign slot_in_range = slot_wide < SW'(SLOTS);
   assign slot_idx      = slot_wide[IW-1:0];
   assign clamped       = (period_ff < min_period_ff) ? min_period_ff : period_ff;

   // entries never written read as their reset values
   assign el_cur = rd_el_ok_ff ? rd_elapsed_ff : '0;
   assign pe_cur = rd_pe_ok_ff ? rd_period_ff : MIN_PERIOD_RESET;
   assign due    = enabled_ff[rd_idx_ff] && (el_cur >= pe_cur);

   always_comb begin
      el_next = el_cur;
      if (op_ff == OP_TICK) begin
         if (el_cur != COUNT_MAX) begin
            el_next = el_cur + COUNT_W'(1);
         end
      end else if (due) begin
         el_next = '0;
      end
   end

   assign mask_ext       = EW'(mask_ff);
   assign sts.idx_last   = (idx_ff == IW'(SLOTS - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_mask = rsp_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= MIN_PERIOD_RESET;
      end else if (csr_write_enable) begin
         min_period_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_operation);
         slot_ff    <= req_slot;
         period_ff  <= req_period;
         handler_ff <= req_has_handler;
      end
   end

   // sweep index and read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_issue;
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.rd_issue) begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_idx_ff     <= idx_ff;
         rd_elapsed_ff <= elapsed_mem[idx_ff];
         rd_period_ff  <= period_mem[idx_ff];
         rd_el_ok_ff   <= elapsed_ok_ff[idx_ff];
         rd_pe_ok_ff   <= period_ok_ff[idx_ff];
      end
   end

   // memory writes: sweep update or single-slot add/delete
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         elapsed_mem[rd_idx_ff] <= el_next;
      end else if (cmd.single_write && slot_in_range && op_ff == OP_ADD) begin
         elapsed_mem[slot_idx] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single_write && slot_in_range) begin
         period_mem[slot_idx] <= (op_ff == OP_ADD) ? clamped : min_period_ff;
      end
   end

   // flag vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ok_ff <= '0;
         period_ok_ff  <= '0;
         enabled_ff    <= '0;
         action_ff     <= '0;
      end else begin
         if (rd_valid_ff) begin
            elapsed_ok_ff[rd_idx_ff] <= 1'b1;
         end else if (cmd.single_write && slot_in_range) begin
            period_ok_ff[slot_idx] <= 1'b1;
            if (op_ff == OP_ADD) begin
               elapsed_ok_ff[slot_idx] <= 1'b1;
               enabled_ff[slot_idx]    <= 1'b1;
               action_ff[slot_idx]     <= handler_ff;
            end else begin
               enabled_ff[slot_idx] <= 1'b0;
               action_ff[slot_idx]  <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= '0;
      end else if (rd_valid_ff && op_ff == OP_POLL && due && action_ff[rd_idx_ff]) begin
         mask_ff[rd_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_mask_ff <= mask_ext[MASK_W-1:0];
      end
   end

endmodule

`default_nettype wire

### rtl/periodic_event_slot_timer.sv
// Top level of the periodic event slot timer: joins the sequencer and the
// datapath. Needs pest_pkg, pest_ctrl and pest_datapath.
//
// Usage:
//  - req_* carries one transaction: operation (tick, poll, add, delete),
//    slot, period and has_handler. It is taken when req_valid and
//    req_ready are both high.
//  - Every transaction gives exactly one result on rsp_*: fired_mask holds
//    the slots that fired on a poll and is zero for tick, add and delete.
//  - csr_write_enable writes min_period from csr_write_data in the same
//    cycle; write it only while the block is idle.
//  - Tick and poll sweep all SLOTS entries of the count and period stores,
//    one slot a cycle through a single read port with a registered read.
//    Add and delete touch one slot.
//  - A new transaction is taken in the cycle after its predecessor's result
//    enters the output register: one transaction is worked on at a time.
//  - When the receiver stalls, the result holds in the output register; one
//    more transaction may be taken and worked on, then its result waits
//    until the register frees.
//  - Reset clears all slots (disabled, no action, count zero, period 10),
//    restores min_period to 10 and empties the output register.
`default_nettype none

module periodic_event_slot_timer #(
   parameter int SLOTS = pest_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pest_pkg::OP_W-1:0]     req_operation,
   input  wire logic [pest_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [pest_pkg::COUNT_W-1:0]  req_period,
   input  wire logic                          req_has_handler,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [pest_pkg::MASK_W-1:0]        rsp_fired_mask,
   input  wire logic                          csr_write_enable,
   input  wire logic [pest_pkg::COUNT_W-1:0]  csr_write_data
);
   import pest_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // sequencer: decides single write or sweep, waits for the output register
   pest_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   // stores, sweep pipeline, configuration and output register
   pest_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_period       (req_period),
      .req_has_handler  (req_has_handler),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_mask   (rsp_fired_mask)
   );

endmodule

`default_nettype wire

### rtl/pest_checker.sv
// Port-level checks for the periodic event slot timer, bound to the top
// level. Needs periodic_event_slot_timer and pest_pkg.
`default_nettype none

module pest_checker #(
   parameter int SLOTS = pest_pkg::SLOTS_DEFAULT
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [pest_pkg::MASK_W-1:0] rsp_fired_mask
);
   import pest_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired_mask))
      else $error("result changed while stalled");

   // one transaction at a time: ready drops after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in work");

   // reset leaves the block idle with no result pending
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // no slot beyond the bank ever fires
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fired_mask >> SLOTS) == '0)
      else $error("fired bit set for a slot outside the bank");

endmodule

bind periodic_event_slot_timer pest_checker #(
   .SLOTS (SLOTS)
) u_pest_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_fired_mask (rsp_fired_mask)
);

`default_nettype wire
